// ----- sv/process_timer_with_prealarm_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Process timer assertion macros
// Shared property forms for the timer checker; clk and rst must be in scope.
// ----------------------------------------------------------------------------
`ifndef PROCESS_TIMER_WITH_PREALARM_UNIT_ASSERT_SVH
`define PROCESS_TIMER_WITH_PREALARM_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define PTP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define PTP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds through reset
`define PTP_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ptp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptp_pkg
// Types, codes and constants of the process timer with prealarm.
// ----------------------------------------------------------------------------
package ptp_pkg;

  localparam int PADDR_W    = 5;
  localparam int PDATA_W    = 32;
  localparam int PIPE_DEPTH = 4;

  localparam logic [15:0] MS_PER_SECOND = 16'd1000;
  localparam logic [15:0] MS_PER_MINUTE = 16'd60000;

  // floor(2^32 / d); quotient estimate is low by at most one
  localparam int RECIP_W = 23;
  localparam int QUO_W   = 23;
  localparam logic [RECIP_W-1:0] RECIP_SECOND =
    RECIP_W'(64'h1_0000_0000 / 64'(MS_PER_SECOND));
  localparam logic [RECIP_W-1:0] RECIP_MINUTE =
    RECIP_W'(64'h1_0000_0000 / 64'(MS_PER_MINUTE));

  typedef enum logic [2:0] {
    ST_STOP     = 3'd0,
    ST_NORMAL   = 3'd1,
    ST_PREALARM = 3'd2,
    ST_COUNTUP  = 3'd3,
    ST_RUN      = 3'd4,
    ST_PAUSED   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_STOP    = 3'd1,
    CMD_RESTART = 3'd2,
    CMD_START   = 3'd3,
    CMD_WAIT    = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    REG_PRESET  = 3'd0,
    REG_MARGIN  = 3'd1,
    REG_PERIODIC = 3'd2,
    REG_MINUTES = 3'd3,
    REG_PERIOD  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] preset_ms;
    logic [31:0] margin_ms;
    logic        periodic;
    logic        minutes;
    logic [13:0] period_ms;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] elapsed_ms;
    logic [31:0] remaining;
    logic        forced;
    logic        minutes;
  } stage_t;

endpackage

// ----- sv/ptp_scan_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptp_scan_if
// Scan channel: one control scan per beat.
// ----------------------------------------------------------------------------
interface ptp_scan_if;
  logic       valid;
  logic       ready;
  logic       basic_scan;
  logic [7:0] elapsed_periods;
  logic [2:0] command;
  logic       out_of_service;

  modport source (output valid, basic_scan, elapsed_periods, command, out_of_service,
                  input ready);
  modport sink (input valid, basic_scan, elapsed_periods, command, out_of_service,
                output ready);
endinterface

// ----- sv/ptp_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptp_result_if
// Result channel: one timer report per beat.
// ----------------------------------------------------------------------------
interface ptp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] elapsed_units;
  logic [31:0] remaining_ms;
  logic        forced_out_of_service;

  modport source (output valid, status, elapsed_units, remaining_ms, forced_out_of_service,
                  input ready);
  modport sink (input valid, status, elapsed_units, remaining_ms, forced_out_of_service,
                output ready);
endinterface

// ----- sv/ptp_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptp_cfg
// APB register file; keeps preset and margin scaled to milliseconds.
// ----------------------------------------------------------------------------
module ptp_cfg
  import ptp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [15:0] preset_time;
  logic [15:0] prealarm_margin;
  logic        periodic_mode;
  logic        minutes_unit;
  logic [13:0] control_period_ms;
  logic [31:0] preset_ms;
  logic [31:0] margin_ms;
  logic [15:0] scale;
  reg_idx_t    idx;
  logic        wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign scale  = minutes_unit ? MS_PER_MINUTE : MS_PER_SECOND;

  always_ff @(posedge clk) begin
    if (rst) begin
      preset_time       <= '0;
      prealarm_margin   <= '0;
      periodic_mode     <= 1'b0;
      minutes_unit      <= 1'b0;
      control_period_ms <= 14'd1000;
      preset_ms         <= '0;
      margin_ms         <= '0;
    end else begin
      if (wr) begin
        unique case (idx)
          REG_PRESET:   preset_time       <= pwdata[15:0];
          REG_MARGIN:   prealarm_margin   <= pwdata[15:0];
          REG_PERIODIC: periodic_mode     <= pwdata[0];
          REG_MINUTES:  minutes_unit      <= pwdata[0];
          REG_PERIOD:   control_period_ms <= pwdata[13:0];
          default: ;
        endcase
      end
      // 16x16 products registered from the stored fields, so they settle after a write
      preset_ms <= 32'(preset_time) * 32'(scale);
      margin_ms <= 32'(prealarm_margin) * 32'(scale);
    end
  end

  always_comb begin
    unique case (idx)
      REG_PRESET:   prdata = PDATA_W'(preset_time);
      REG_MARGIN:   prdata = PDATA_W'(prealarm_margin);
      REG_PERIODIC: prdata = PDATA_W'(periodic_mode);
      REG_MINUTES:  prdata = PDATA_W'(minutes_unit);
      REG_PERIOD:   prdata = PDATA_W'(control_period_ms);
      default:      prdata = '0;
    endcase
  end

  assign cfg.preset_ms = preset_ms;
  assign cfg.margin_ms = margin_ms;
  assign cfg.periodic  = periodic_mode;
  assign cfg.minutes   = minutes_unit;
  assign cfg.period_ms = control_period_ms;

endmodule

// ----- sv/ptp_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptp_core
// Scan input register, timer state and combinational state update.
// ----------------------------------------------------------------------------
module ptp_core
  import ptp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  ptp_scan_if.sink scan,
  input  cfg_t  cfg,
  output logic  res_valid,
  input  logic  res_ready,
  output stage_t res
);

  // input register
  logic        s1_valid;
  logic        s1_scan;
  logic [21:0] s1_incr;
  cmd_t        s1_cmd;
  logic        s1_oos;

  // timer state
  logic [31:0] elapsed_ms;
  status_t     run_status;
  logic [31:0] remaining_time;
  cmd_t        last_command;
  status_t     saved_status;
  logic        saved_valid;

  logic [31:0] elapsed_ms_next;
  status_t     run_status_next;
  logic [31:0] remaining_time_next;
  cmd_t        last_command_next;
  status_t     saved_status_next;
  logic        saved_valid_next;

  logic [32:0] sum;
  logic [31:0] sum_sat;
  logic [31:0] left;
  logic        fire;

  assign scan.ready = !s1_valid || res_ready;
  assign fire       = s1_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (scan.ready) begin
      s1_valid <= scan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scan.valid && scan.ready) begin
      s1_scan <= scan.basic_scan;
      s1_incr <= 22'(cfg.period_ms) * 22'(scan.elapsed_periods);
      s1_cmd  <= cmd_t'(scan.command);
      s1_oos  <= scan.out_of_service;
    end
  end

  always_comb begin
    elapsed_ms_next     = elapsed_ms;
    run_status_next     = run_status;
    remaining_time_next = remaining_time;
    last_command_next   = last_command;
    saved_status_next   = saved_status;
    saved_valid_next    = saved_valid;
    sum                 = '0;
    sum_sat             = '0;
    left                = '0;
    if (s1_scan && !s1_oos) begin
      unique case (s1_cmd)
        CMD_STOP: begin
          run_status_next   = ST_STOP;
          last_command_next = CMD_STOP;
        end
        CMD_START: begin
          if (last_command != CMD_START) begin
            run_status_next = ST_RUN;
            elapsed_ms_next = '0;
          end
          last_command_next = CMD_START;
        end
        CMD_RESTART: begin
          if (last_command != CMD_RESTART) begin
            run_status_next  = saved_valid ? saved_status : ST_RUN;
            saved_valid_next = 1'b0;
          end
          last_command_next = CMD_RESTART;
        end
        CMD_WAIT: begin
          if (!saved_valid && run_status != ST_PAUSED) begin
            saved_status_next = run_status;
            saved_valid_next  = 1'b1;
          end
          run_status_next = ST_PAUSED;
        end
        default: ;
      endcase

      if (run_status_next == ST_RUN || run_status_next == ST_NORMAL ||
          run_status_next == ST_PREALARM) begin
        sum     = {1'b0, elapsed_ms_next} + 33'(s1_incr);
        sum_sat = sum[32] ? '1 : sum[31:0];
        if (sum_sat >= cfg.preset_ms) begin
          if (cfg.periodic) begin
            elapsed_ms_next     = '0;
            run_status_next     = ST_NORMAL;
            remaining_time_next = cfg.preset_ms;
          end else begin
            elapsed_ms_next     = cfg.preset_ms;
            run_status_next     = ST_COUNTUP;
            remaining_time_next = '0;
          end
        end else begin
          left                = cfg.preset_ms - sum_sat;
          elapsed_ms_next     = sum_sat;
          remaining_time_next = left;
          run_status_next     = (left <= cfg.margin_ms) ? ST_PREALARM : ST_NORMAL;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_ms     <= '0;
      run_status     <= ST_STOP;
      remaining_time <= '0;
      last_command   <= CMD_NONE;
      saved_status   <= ST_STOP;
      saved_valid    <= 1'b0;
    end else if (fire) begin
      elapsed_ms     <= elapsed_ms_next;
      run_status     <= run_status_next;
      remaining_time <= remaining_time_next;
      last_command   <= last_command_next;
      saved_status   <= saved_status_next;
      saved_valid    <= saved_valid_next;
    end
  end

  assign res_valid      = s1_valid;
  assign res.status     = run_status_next;
  assign res.elapsed_ms = elapsed_ms_next;
  assign res.remaining  = remaining_time_next;
  assign res.forced     = s1_scan && s1_oos;
  assign res.minutes    = cfg.minutes;

endmodule

// ----- sv/ptp_units.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptp_units
// Elapsed ms to whole units: reciprocal multiply, correction, output register.
// ----------------------------------------------------------------------------
module ptp_units
  import ptp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   res_valid,
  output logic   res_ready,
  input  stage_t res,
  ptp_result_if.source result
);

  logic   s2_valid, s3_valid, s4_valid;
  logic   ready2, ready3, ready4;
  stage_t s2, s3;

  logic [RECIP_W-1:0]       recip;
  logic [32+RECIP_W-1:0]    prod;
  logic [QUO_W-1:0]         s3_quo;
  logic [15:0]              divisor;
  logic [QUO_W+15:0]        qd;
  logic [31:0]              rem;
  logic [QUO_W:0]           quo_fix;

  status_t     s4_status;
  logic [15:0] s4_units;
  logic [31:0] s4_remaining;
  logic        s4_forced;

  assign ready4    = !s4_valid || result.ready;
  assign ready3    = !s3_valid || ready4;
  assign ready2    = !s2_valid || ready3;
  assign res_ready = ready2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      if (ready2) s2_valid <= res_valid;
      if (ready3) s3_valid <= s2_valid;
      if (ready4) s4_valid <= s3_valid;
    end
  end

  // estimate: floor(e * floor(2^32/d) / 2^32), low by at most one
  assign recip = s2.minutes ? RECIP_MINUTE : RECIP_SECOND;
  assign prod  = (32+RECIP_W)'(s2.elapsed_ms) * (32+RECIP_W)'(recip);

  // one correction step, then clamp to 16 bits
  assign divisor = s3.minutes ? MS_PER_MINUTE : MS_PER_SECOND;
  assign qd      = (QUO_W+16)'(s3_quo) * (QUO_W+16)'(divisor);
  assign rem     = s3.elapsed_ms - qd[31:0];
  assign quo_fix = (rem >= 32'(divisor)) ? {1'b0, s3_quo} + 1'b1 : {1'b0, s3_quo};

  always_ff @(posedge clk) begin
    if (ready2) s2 <= res;
    if (ready3) begin
      s3     <= s2;
      s3_quo <= prod[32 +: QUO_W];
    end
    if (ready4) begin
      s4_status    <= s3.status;
      s4_units     <= (quo_fix > (QUO_W+1)'(16'hFFFF)) ? 16'hFFFF : quo_fix[15:0];
      s4_remaining <= s3.remaining;
      s4_forced    <= s3.forced;
    end
  end

  assign result.valid                 = s4_valid;
  assign result.status                = s4_status;
  assign result.elapsed_units         = s4_units;
  assign result.remaining_ms          = s4_remaining;
  assign result.forced_out_of_service = s4_forced;

endmodule

// ----- sv/process_timer_with_prealarm_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// process_timer_with_prealarm_unit
// Batch timer driven by control scans, with prealarm and count-up status.
// ----------------------------------------------------------------------------
// One scan beat is accepted every clock cycle while the result side does not
// stall, and its report beat passes through the input register, state
// update, quotient estimate and correction into the output register.
// The throughput of one scan per cycle is set by the state-update stage: the
// command decode, elapsed-time add with saturation, preset compare and margin
// compare all close within that stage so the next scan sees the new state.
// Each pipeline stage holds its beat under backpressure and bubbles
// collapse, so scans keep flowing into empty stages while a finished report
// waits. Configuration goes through the APB port: preset (0x00), prealarm
// margin (0x04), periodic mode (0x08), minutes unit (0x0C), control period
// in ms (0x10); pready is always high and reads return the stored value.
// Preset and margin are scaled to milliseconds in registered products after
// a write, so let them settle before the next scan. No clearing pass after reset.
// ----------------------------------------------------------------------------
module process_timer_with_prealarm_unit
  import ptp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  ptp_scan_if.sink           scan,
  ptp_result_if.source       result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t   cfg;
  stage_t res;
  logic   res_valid;
  logic   res_ready;

  // register file, ms-scaled limits
  ptp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // scan register and timer state update
  ptp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .scan      (scan),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // ms to whole seconds/minutes, output register
  ptp_units u_units (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .result    (result)
  );

endmodule

// ----- sv/ptp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptp_checker
// Port-level checks of the timer: beat hold, no spurious result, in-flight bound, reset.
// ----------------------------------------------------------------------------
`include "process_timer_with_prealarm_unit_assert.svh"

module ptp_checker
  import ptp_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic scan_valid,
  input logic scan_ready,
  input logic result_valid,
  input logic result_ready
);

  logic [2:0] outstanding;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = scan_valid && scan_ready;
  assign out_beat = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 3'(in_beat) - 3'(out_beat);
    end
  end

  `PTP_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid, "result beat dropped while stalled")
  `PTP_ASSERT_IMP(a_no_spurious, result_valid, outstanding != 3'd0, "result beat without a scan in flight")
  `PTP_ASSERT_IMP(a_depth, in_beat, outstanding < 3'(PIPE_DEPTH) || out_beat, "scan taken with pipeline full")
  `PTP_ASSERT_RST(a_reset_empty, rst, !result_valid, "result valid right after reset")

endmodule

bind process_timer_with_prealarm_unit ptp_checker u_ptp_checker (
  .clk          (clk),
  .rst          (rst),
  .scan_valid   (scan.valid),
  .scan_ready   (scan.ready),
  .result_valid (result.valid),
  .result_ready (result.ready)
);
